/* rtl/hpt_pkg.sv */
// ----------------------------------------------------------------------------
// hpt_pkg
// shared types, codes and sizes of the histogram with peak tracking
// ----------------------------------------------------------------------------
package hpt_pkg;

    localparam int MAX_BINS    = 1024;
    localparam int BIN_BITS    = $clog2(MAX_BINS);
    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 32;
    localparam int BCNT_BITS   = BIN_BITS + 1;
    localparam int SPAN_BITS   = SAMPLE_BITS;
    localparam int REM_BITS    = SPAN_BITS + BIN_BITS;

    localparam logic [COUNT_BITS-1:0] FULL_COUNT = '1;

    // register reset values
    localparam logic [SAMPLE_BITS-1:0] RANGE_MIN_RST  = SAMPLE_BITS'(16'h8000);
    localparam logic [SAMPLE_BITS-1:0] RANGE_MAX_RST  = SAMPLE_BITS'(16'h7FFF);
    localparam logic [BCNT_BITS-1:0]   BIN_COUNT_RST  = BCNT_BITS'(MAX_BINS);
    localparam logic [SAMPLE_BITS-1:0] HOLE_LEVEL_RST = SAMPLE_BITS'(16'h7FFF);

    typedef enum logic [1:0] {
        REG_RANGE_MIN  = 2'd0,
        REG_RANGE_MAX  = 2'd1,
        REG_BIN_COUNT  = 2'd2,
        REG_HOLE_LEVEL = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_READ     = 2'd1,
        CMD_CLR_BIN  = 2'd2,
        CMD_CLR_PEAK = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_COUNTED   = 3'd0,
        ST_HOLE      = 3'd1,
        ST_BELOW     = 3'd2,
        ST_ABOVE     = 3'd3,
        ST_BAD_RANGE = 3'd4,
        ST_DONE      = 3'd5
    } t_status;

    // what the back end has to do for one request
    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_STATUS   = 3'd1,
        OP_READ     = 3'd2,
        OP_CLR_BIN  = 3'd3,
        OP_CLR_PEAK = 3'd4
    } t_op_kind;

    typedef struct packed {
        t_op_kind            kind;
        t_status             status;
        logic [BIN_BITS-1:0] idx;
    } t_op;

endpackage

/* rtl/histogram_with_peak_tracking.sv */
// ----------------------------------------------------------------------------
// histogram_with_peak_tracking
// histogram of signed samples into a 1024-bin store with peak and mode tracking
// ----------------------------------------------------------------------------
// add sample: bin index by 10-step long division in the front end, others skip it
// the front end takes a new request only after the last one has gone into the queue;
//   the back end takes one only after the store read-modify-write of the last one
// reset: synchronous active low; registers return to their defaults, then a clearing
//   pass zeroes the bin store, and no request is taken until it ends
// ----------------------------------------------------------------------------
module histogram_with_peak_tracking (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_index,
    input  logic [hpt_pkg::SAMPLE_BITS-1:0] i_cfg_data,
    // request channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_command,
    input  logic [hpt_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [hpt_pkg::BIN_BITS-1:0]    i_bin_select,
    // result channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [2:0]                      o_status,
    output logic [hpt_pkg::BIN_BITS-1:0]    o_bin_index,
    output logic [hpt_pkg::COUNT_BITS-1:0]  o_bin_value,
    output logic [hpt_pkg::COUNT_BITS-1:0]  o_peak_value,
    output logic [hpt_pkg::BIN_BITS-1:0]    o_peak_bin
);

    // front end to queue
    logic         front_valid, front_ready;
    hpt_pkg::t_op front_op;
    // queue to back end
    logic         back_valid, back_ready;
    hpt_pkg::t_op back_op;
    // back end still sweeping the store after reset
    logic         back_busy;

    // front end: register file, range and hole checks, bin index division
    hpt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_sample     (i_sample),
        .i_bin_select (i_bin_select),
        .i_back_busy  (back_busy),
        .o_op_valid   (front_valid),
        .i_op_ready   (front_ready),
        .o_op         (front_op)
    );

    // short queue so the divider keeps going while the back end waits on the output
    hpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_op    (front_op),
        .o_valid (back_valid),
        .i_ready (back_ready),
        .o_op    (back_op)
    );

    // back end: bin store read-modify-write, peak and mode, result register
    hpt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_valid   (back_valid),
        .o_op_ready   (back_ready),
        .i_op         (back_op),
        .o_busy       (back_busy),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_bin_index  (o_bin_index),
        .o_bin_value  (o_bin_value),
        .o_peak_value (o_peak_value),
        .o_peak_bin   (o_peak_bin)
    );

endmodule

/* rtl/hpt_front.sv */
// ----------------------------------------------------------------------------
// hpt_front
// takes requests, checks range and hole, computes the bin by long division
// ----------------------------------------------------------------------------
module hpt_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_index,
    input  logic [hpt_pkg::SAMPLE_BITS-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_command,
    input  logic [hpt_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [hpt_pkg::BIN_BITS-1:0]    i_bin_select,
    input  logic                            i_back_busy,
    output logic                            o_op_valid,
    input  logic                            i_op_ready,
    output hpt_pkg::t_op                    o_op
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_DIV  = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    localparam int STEP_BITS = $clog2(hpt_pkg::BIN_BITS);

    t_fstate r_state, n_state;

    logic signed [hpt_pkg::SAMPLE_BITS-1:0] r_range_min, r_range_max, r_hole_level;
    logic [hpt_pkg::BCNT_BITS-1:0]          r_bin_count;

    logic [hpt_pkg::SPAN_BITS-1:0] r_diff, n_diff;
    logic [hpt_pkg::SPAN_BITS-1:0] r_span, n_span;
    logic [hpt_pkg::BIN_BITS-1:0]  r_scale, n_scale;
    logic [hpt_pkg::REM_BITS-1:0]  r_rem, n_rem;
    logic [hpt_pkg::BIN_BITS-1:0]  r_quot, n_quot;
    logic [STEP_BITS-1:0]          r_step, n_step;
    hpt_pkg::t_op                  r_op, n_op;

    logic signed [hpt_pkg::SAMPLE_BITS-1:0] sample_s;
    logic signed [hpt_pkg::SAMPLE_BITS:0]   diff_w, span_w;
    logic                                   bad_range;
    logic [hpt_pkg::REM_BITS-1:0]           trial;

    assign sample_s   = i_sample;
    assign diff_w     = {sample_s[hpt_pkg::SAMPLE_BITS-1], sample_s}
                      - {r_range_min[hpt_pkg::SAMPLE_BITS-1], r_range_min};
    assign span_w     = {r_range_max[hpt_pkg::SAMPLE_BITS-1], r_range_max}
                      - {r_range_min[hpt_pkg::SAMPLE_BITS-1], r_range_min};
    assign bad_range  = (r_range_min >= r_range_max)
                      || (r_bin_count < hpt_pkg::BCNT_BITS'(2))
                      || (r_bin_count > hpt_pkg::BCNT_BITS'(hpt_pkg::MAX_BINS));
    assign trial      = hpt_pkg::REM_BITS'(r_span) << r_step;

    assign o_ready    = (r_state == F_IDLE) && !i_back_busy;
    assign o_op_valid = (r_state == F_PUSH);
    assign o_op       = r_op;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min  <= hpt_pkg::RANGE_MIN_RST;
            r_range_max  <= hpt_pkg::RANGE_MAX_RST;
            r_bin_count  <= hpt_pkg::BIN_COUNT_RST;
            r_hole_level <= hpt_pkg::HOLE_LEVEL_RST;
        end else if (i_cfg_we) begin
            unique case (hpt_pkg::t_reg_idx'(i_cfg_index))
                hpt_pkg::REG_RANGE_MIN:  r_range_min  <= i_cfg_data;
                hpt_pkg::REG_RANGE_MAX:  r_range_max  <= i_cfg_data;
                hpt_pkg::REG_BIN_COUNT:  r_bin_count  <= i_cfg_data[hpt_pkg::BCNT_BITS-1:0];
                hpt_pkg::REG_HOLE_LEVEL: r_hole_level <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_diff  = r_diff;
        n_span  = r_span;
        n_scale = r_scale;
        n_rem   = r_rem;
        n_quot  = r_quot;
        n_step  = r_step;
        n_op    = r_op;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid && o_ready) begin
                    n_state = F_PUSH;
                    n_op.idx    = '0;
                    n_op.status = hpt_pkg::ST_DONE;
                    unique case (hpt_pkg::t_cmd'(i_command))
                        hpt_pkg::CMD_ADD: begin
                            n_op.kind = hpt_pkg::OP_STATUS;
                            // order matters: bad range, hole, below, above
                            if (bad_range) begin
                                n_op.status = hpt_pkg::ST_BAD_RANGE;
                            end else if (sample_s >= r_hole_level) begin
                                n_op.status = hpt_pkg::ST_HOLE;
                            end else if (sample_s < r_range_min) begin
                                n_op.status = hpt_pkg::ST_BELOW;
                            end else if (sample_s > r_range_max) begin
                                n_op.status = hpt_pkg::ST_ABOVE;
                            end else begin
                                n_op.kind   = hpt_pkg::OP_ADD;
                                n_op.status = hpt_pkg::ST_COUNTED;
                                n_diff  = diff_w[hpt_pkg::SPAN_BITS-1:0];
                                n_span  = span_w[hpt_pkg::SPAN_BITS-1:0];
                                n_scale = hpt_pkg::BIN_BITS'(r_bin_count - 1'b1);
                                n_state = F_MUL;
                            end
                        end
                        hpt_pkg::CMD_READ: begin
                            n_op.kind = hpt_pkg::OP_READ;
                            n_op.idx  = i_bin_select;
                        end
                        hpt_pkg::CMD_CLR_BIN: begin
                            n_op.kind = hpt_pkg::OP_CLR_BIN;
                            n_op.idx  = i_bin_select;
                        end
                        hpt_pkg::CMD_CLR_PEAK: begin
                            n_op.kind = hpt_pkg::OP_CLR_PEAK;
                        end
                        default: ;
                    endcase
                end
            end
            F_MUL: begin
                n_rem   = hpt_pkg::REM_BITS'(r_diff) * hpt_pkg::REM_BITS'(r_scale);
                n_quot  = '0;
                n_step  = STEP_BITS'(hpt_pkg::BIN_BITS - 1);
                n_state = F_DIV;
            end
            F_DIV: begin
                // quotient never exceeds bin_count - 1, so BIN_BITS steps suffice
                if (r_rem >= trial) begin
                    n_rem  = r_rem - trial;
                    n_quot = {r_quot[hpt_pkg::BIN_BITS-2:0], 1'b1};
                end else begin
                    n_quot = {r_quot[hpt_pkg::BIN_BITS-2:0], 1'b0};
                end
                if (r_step == '0) begin
                    n_op.idx = n_quot;
                    n_state  = F_PUSH;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            F_PUSH: begin
                if (i_op_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff  <= n_diff;
        r_span  <= n_span;
        r_scale <= n_scale;
        r_rem   <= n_rem;
        r_quot  <= n_quot;
        r_step  <= n_step;
        r_op    <= n_op;
    end

endmodule

/* rtl/hpt_queue.sv */
// ----------------------------------------------------------------------------
// hpt_queue
// two-entry request queue between front and back end
// ----------------------------------------------------------------------------
module hpt_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  hpt_pkg::t_op i_op,
    output logic         o_valid,
    input  logic         i_ready,
    output hpt_pkg::t_op o_op
);

    hpt_pkg::t_op r_mem [2];
    logic         r_wr_ptr, r_rd_ptr;
    logic [1:0]   r_count;
    logic         push, pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_op    = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

/* rtl/hpt_back.sv */
// ----------------------------------------------------------------------------
// hpt_back
// bin store read-modify-write, peak tracking, result register
// ----------------------------------------------------------------------------
module hpt_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_op_valid,
    output logic                           o_op_ready,
    input  hpt_pkg::t_op                   i_op,
    output logic                           o_busy,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [2:0]                     o_status,
    output logic [hpt_pkg::BIN_BITS-1:0]   o_bin_index,
    output logic [hpt_pkg::COUNT_BITS-1:0] o_bin_value,
    output logic [hpt_pkg::COUNT_BITS-1:0] o_peak_value,
    output logic [hpt_pkg::BIN_BITS-1:0]   o_peak_bin
);

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_EXEC  = 3'b100
    } t_bstate;

    t_bstate r_state, n_state;

    logic [hpt_pkg::COUNT_BITS-1:0] r_store [hpt_pkg::MAX_BINS];
    logic [hpt_pkg::COUNT_BITS-1:0] r_rd_data;
    logic [hpt_pkg::BIN_BITS-1:0]   r_clr_addr;
    hpt_pkg::t_op                   r_op;

    logic [hpt_pkg::COUNT_BITS-1:0] r_peak, n_peak;
    logic [hpt_pkg::BIN_BITS-1:0]   r_mode, n_mode;

    logic                           r_out_valid;
    hpt_pkg::t_status               r_out_status, n_out_status;
    logic [hpt_pkg::BIN_BITS-1:0]   r_out_idx, n_out_idx;
    logic [hpt_pkg::COUNT_BITS-1:0] r_out_val, n_out_val;

    logic                           take, fire;
    logic                           wr_en;
    logic [hpt_pkg::BIN_BITS-1:0]   wr_addr;
    logic [hpt_pkg::COUNT_BITS-1:0] wr_data;
    logic [hpt_pkg::COUNT_BITS-1:0] inc_val;

    assign o_busy     = (r_state == B_CLEAR);
    assign o_op_ready = (r_state == B_IDLE);
    assign take       = i_op_valid && o_op_ready;
    assign fire       = (r_state == B_EXEC) && (!r_out_valid || i_ready);
    assign inc_val    = (r_rd_data == hpt_pkg::FULL_COUNT) ? r_rd_data
                                                           : r_rd_data + 1'b1;

    always_comb begin
        n_state      = r_state;
        n_peak       = r_peak;
        n_mode       = r_mode;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        n_out_val    = r_out_val;
        wr_en        = 1'b0;
        wr_addr      = r_op.idx;
        wr_data      = '0;
        unique case (r_state)
            B_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
                if (r_clr_addr == hpt_pkg::BIN_BITS'(hpt_pkg::MAX_BINS - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (take) begin
                    n_state = B_EXEC;
                end
            end
            B_EXEC: begin
                if (fire) begin
                    n_state      = B_IDLE;
                    n_out_status = r_op.status;
                    n_out_idx    = '0;
                    n_out_val    = '0;
                    unique case (r_op.kind)
                        hpt_pkg::OP_ADD: begin
                            wr_en     = 1'b1;
                            wr_data   = inc_val;
                            n_out_idx = r_op.idx;
                            n_out_val = inc_val;
                            if (inc_val > r_peak) begin
                                n_peak = inc_val;
                                n_mode = r_op.idx;
                            end
                        end
                        hpt_pkg::OP_READ: begin
                            n_out_idx = r_op.idx;
                            n_out_val = r_rd_data;
                        end
                        hpt_pkg::OP_CLR_BIN: begin
                            wr_en     = 1'b1;
                            n_out_idx = r_op.idx;
                        end
                        hpt_pkg::OP_CLR_PEAK: begin
                            n_peak = '0;
                            n_mode = '0;
                        end
                        default: ;
                    endcase
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_peak      <= '0;
            r_mode      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_peak  <= n_peak;
            r_mode  <= n_mode;
            if (r_state == B_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // bin store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rd_data <= r_store[i_op.idx];
            r_op      <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
        r_out_val    <= n_out_val;
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_bin_index  = r_out_idx;
    assign o_bin_value  = r_out_val;
    assign o_peak_value = r_peak;
    assign o_peak_bin   = r_mode;

    // the peak only drops on a clear-peak request
    a_peak_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_op.kind != hpt_pkg::OP_CLR_PEAK) |=> (r_peak >= $past(r_peak)))
        else $error("peak count decreased");

    // a counted sample always leaves a nonzero bin no larger than the peak
    a_counted_vs_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == hpt_pkg::ST_COUNTED)
            |-> (r_out_val != '0 && r_out_val <= r_peak))
        else $error("counted bin value inconsistent with peak");

    // no request leaves the queue while the store is being cleared
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CLEAR) |=> !$past(take))
        else $error("request taken during store clear");

endmodule
